>>> rtl/core/pj_pkg.sv
// Shared widths, types and numerator indexes for the projection Jacobian block.
package pj_pkg;

  localparam int PW = 32;              // input point / register width
  localparam int OW = 48;              // output entry width, signed Q32.16
  localparam int MW = 97;              // numerator magnitude width
  localparam int DW = 63;              // denominator width, Z*Z up to 2^62
  localparam int LANES = 6;            // entries per row
  localparam int NUM_COUNT = 13;       // distinct numerators per point
  localparam int QUEUE_DEPTH_DEF = 8;

  // lane order on the result channel
  localparam int LANE_TX = 0;
  localparam int LANE_TY = 1;
  localparam int LANE_TZ = 2;
  localparam int LANE_RX = 3;
  localparam int LANE_RY = 4;
  localparam int LANE_RZ = 5;

  localparam logic [1:0] ROW_LEFT_U  = 2'd0;
  localparam logic [1:0] ROW_V       = 2'd1;
  localparam logic [1:0] ROW_RIGHT_U = 2'd2;

  // numerator slots of one point
  localparam int NI_U_TX = 0;
  localparam int NI_U_TZ = 1;
  localparam int NI_U_RX = 2;
  localparam int NI_U_RY = 3;
  localparam int NI_U_RZ = 4;
  localparam int NI_V_TY = 5;
  localparam int NI_V_TZ = 6;
  localparam int NI_V_RX = 7;
  localparam int NI_V_RY = 8;
  localparam int NI_V_RZ = 9;
  localparam int NI_R_TZ = 10;
  localparam int NI_R_RX = 11;
  localparam int NI_R_RY = 12;

  // slots whose formula carries a leading minus
  localparam logic [NUM_COUNT-1:0] NUM_FLIP = 13'b0_1_1_0_0_1_1_0_1_0_1_1_0;

  typedef struct packed {
    logic          neg;
    logic [MW-1:0] mag;
  } num_t;

  typedef struct packed {
    logic [DW-1:0]               den;
    num_t [NUM_COUNT-1:0]        num;
  } job_t;

  typedef struct packed {
    logic vld;
    job_t job;
  } job_req_t;

endpackage

>>> rtl/core/projection_pose_jacobian.sv
// Top level: stereo/mono pinhole projection Jacobian rows w.r.t. a 6-DOF pose.
//
//  channel   direction  handshake              payload
//  in        request    in_valid / in_ready    point_x, point_y, point_z
//  out       result     out_valid / out_ready  row_index, last_row, entry_*, saturated
//  cfg       write      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One result row per cycle leaves the divider pipeline while the result side does not
// stall; the row sequencer feeds the six shared divider lanes 2 rows per point in mono,
// 3 in stereo. A request passes 5 front stages, the queue and 52 back stages.
// Reset clears the config registers, counters and all valid bits; no clearing pass.
// Requests are taken while the queue has room, independent of the result side;
// a stalled result freezes only the back end, from row sequencer to output register.
module projection_pose_jacobian import pj_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [PW-1:0] point_x,
  input  logic signed [PW-1:0] point_y,
  input  logic signed [PW-1:0] point_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           row_index,
  output logic                 last_row,
  output logic signed [OW-1:0] entry_tx,
  output logic signed [OW-1:0] entry_ty,
  output logic signed [OW-1:0] entry_tz,
  output logic signed [OW-1:0] entry_rx,
  output logic signed [OW-1:0] entry_ry,
  output logic signed [OW-1:0] entry_rz,
  output logic                 saturated,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_index,
  input  logic [PW-1:0]        cfg_data
);

  localparam logic [7:0] REG_FOCAL_X  = 8'd0;
  localparam logic [7:0] REG_FOCAL_Y  = 8'd1;
  localparam logic [7:0] REG_BASELINE = 8'd2;
  localparam logic [7:0] REG_STEREO   = 8'd3;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [PW-1:0]        focal_x, focal_y;
  logic signed [PW-1:0] baseline;
  logic                 stereo_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x     <= '0;
      focal_y     <= '0;
      baseline    <= '0;
      stereo_mode <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FOCAL_X:  focal_x     <= cfg_data;
        REG_FOCAL_Y:  focal_y     <= cfg_data;
        REG_BASELINE: baseline    <= $signed(cfg_data);
        REG_STEREO:   stereo_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // points in flight in the front end plus those queued
  logic [CW-1:0] held;
  logic          take, pop;
  job_req_t      push, head;
  logic signed [OW-1:0] entry [LANES];

  assign in_ready = (held < CW'(QUEUE_DEPTH));
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else begin
      held <= held + CW'(take) - CW'(pop);
    end
  end

  pj_front u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .point_x  (point_x),
    .point_y  (point_y),
    .point_z  (point_z),
    .focal_x  (focal_x),
    .focal_y  (focal_y),
    .baseline (baseline),
    .push     (push)
  );

  pj_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head)
  );

  pj_back u_back (
    .clk         (clk),
    .rst         (rst),
    .stereo_mode (stereo_mode),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .row_index   (row_index),
    .last_row    (last_row),
    .entry       (entry),
    .saturated   (saturated)
  );

  assign entry_tx = entry[LANE_TX];
  assign entry_ty = entry[LANE_TY];
  assign entry_tz = entry[LANE_TZ];
  assign entry_rx = entry[LANE_RX];
  assign entry_ry = entry[LANE_RY];
  assign entry_rz = entry[LANE_RZ];

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CW'(QUEUE_DEPTH))
    else $error("point credit count overran queue depth");

  a_pop_needs_job: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.vld && held != '0)
    else $error("queue popped while empty");

  a_right_row_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && row_index == ROW_RIGHT_U |-> last_row)
    else $error("right u row not marked last");

  a_mono_v_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !stereo_mode && row_index == ROW_V |-> last_row)
    else $error("mono v row not marked last");

endmodule

>>> rtl/core/pj_front.sv
// Front end: takes a point and forms the exact numerators and Z*Z for all rows.
module pj_front import pj_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic signed [PW-1:0] point_x,
  input  logic signed [PW-1:0] point_y,
  input  logic signed [PW-1:0] point_z,
  input  logic        [PW-1:0] focal_x,
  input  logic        [PW-1:0] focal_y,
  input  logic signed [PW-1:0] baseline,
  output job_req_t             push
);

  localparam int FM = 8;
  localparam int M_XY_FX = 0;
  localparam int M_SU_FX = 1;
  localparam int M_YZ_FX = 2;
  localparam int M_WY_FX = 3;
  localparam int M_SR_FX = 4;
  localparam int M_SV_FY = 5;
  localparam int M_XY_FY = 6;
  localparam int M_XZ_FY = 7;

  logic signed [PW:0] fxs, fys;
  assign fxs = $signed({1'b0, focal_x});
  assign fys = $signed({1'b0, focal_y});

  // stage 1: point products
  logic                s1_vld, s1_zero;
  logic signed [63:0]  s1_zz, s1_xx, s1_yy, s1_xy, s1_yz, s1_xz, s1_xb, s1_by;
  logic signed [64:0]  s1_zfx, s1_xfx, s1_bfx, s1_zfy, s1_yfy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= take;
    end
    s1_zero <= (point_z == '0);
    s1_zz   <= point_z * point_z;
    s1_xx   <= point_x * point_x;
    s1_yy   <= point_y * point_y;
    s1_xy   <= point_x * point_y;
    s1_yz   <= point_y * point_z;
    s1_xz   <= point_x * point_z;
    s1_xb   <= point_x * baseline;
    s1_by   <= baseline * point_y;
    s1_zfx  <= point_z * fxs;
    s1_xfx  <= point_x * fxs;
    s1_bfx  <= baseline * fxs;
    s1_zfy  <= point_z * fys;
    s1_yfy  <= point_y * fys;
  end

  // stage 2: sums, W = X - baseline folded in
  logic                s2_vld, s2_zero;
  logic [DW-1:0]       s2_den;
  logic signed [65:0]  s2_su, s2_sv, s2_sr, s2_wy, s2_wfx, s2_xy, s2_yz, s2_xz;
  logic signed [64:0]  s2_zfx, s2_xfx, s2_zfy, s2_yfy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
    s2_zero <= s1_zero;
    s2_den  <= s1_zz[DW-1:0];
    s2_su   <= 66'(s1_zz) + 66'(s1_xx);
    s2_sv   <= 66'(s1_zz) + 66'(s1_yy);
    s2_sr   <= 66'(s1_zz) + 66'(s1_xx) - 66'(s1_xb);
    s2_wy   <= 66'(s1_xy) - 66'(s1_by);
    s2_wfx  <= 66'(s1_xfx) - 66'(s1_bfx);
    s2_xy   <= 66'(s1_xy);
    s2_yz   <= 66'(s1_yz);
    s2_xz   <= 66'(s1_xz);
    s2_zfx  <= s1_zfx;
    s2_xfx  <= s1_xfx;
    s2_zfy  <= s1_zfy;
    s2_yfy  <= s1_yfy;
  end

  // stage 3: focal products, split in two partial products
  logic signed [65:0] opa [FM];
  logic signed [PW:0] opf [FM];

  always_comb begin
    opa[M_XY_FX] = s2_xy;  opf[M_XY_FX] = fxs;
    opa[M_SU_FX] = s2_su;  opf[M_SU_FX] = fxs;
    opa[M_YZ_FX] = s2_yz;  opf[M_YZ_FX] = fxs;
    opa[M_WY_FX] = s2_wy;  opf[M_WY_FX] = fxs;
    opa[M_SR_FX] = s2_sr;  opf[M_SR_FX] = fxs;
    opa[M_SV_FY] = s2_sv;  opf[M_SV_FY] = fys;
    opa[M_XY_FY] = s2_xy;  opf[M_XY_FY] = fys;
    opa[M_XZ_FY] = s2_xz;  opf[M_XZ_FY] = fys;
  end

  logic                s3_vld, s3_zero;
  logic [DW-1:0]       s3_den;
  logic [63:0]         s3_lo [FM];
  logic signed [66:0]  s3_hi [FM];
  logic signed [65:0]  s3_wfx;
  logic signed [64:0]  s3_zfx, s3_xfx, s3_zfy, s3_yfy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
    s3_zero <= s2_zero;
    s3_den  <= s2_den;
    s3_wfx  <= s2_wfx;
    s3_zfx  <= s2_zfx;
    s3_xfx  <= s2_xfx;
    s3_zfy  <= s2_zfy;
    s3_yfy  <= s2_yfy;
    for (int i = 0; i < FM; i++) begin
      s3_lo[i] <= opa[i][31:0] * opf[i][PW-1:0];
      s3_hi[i] <= $signed(opa[i][65:32]) * opf[i];
    end
  end

  // stage 4: assemble signed numerators
  logic                 s4_vld, s4_zero;
  logic [DW-1:0]        s4_den;
  logic signed [97:0]   full [FM];
  logic signed [97:0]   s4_val [NUM_COUNT];

  always_comb begin
    for (int i = 0; i < FM; i++) begin
      full[i] = (98'(s3_hi[i]) <<< 32) + $signed(98'(s3_lo[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else begin
      s4_vld <= s3_vld;
    end
    s4_zero <= s3_zero;
    s4_den  <= s3_den;
    s4_val[NI_U_TX] <= 98'(s3_zfx) <<< 16;
    s4_val[NI_U_TZ] <= 98'(s3_xfx) <<< 16;
    s4_val[NI_U_RX] <= full[M_XY_FX];
    s4_val[NI_U_RY] <= full[M_SU_FX];
    s4_val[NI_U_RZ] <= full[M_YZ_FX];
    s4_val[NI_V_TY] <= 98'(s3_zfy) <<< 16;
    s4_val[NI_V_TZ] <= 98'(s3_yfy) <<< 16;
    s4_val[NI_V_RX] <= full[M_SV_FY];
    s4_val[NI_V_RY] <= full[M_XY_FY];
    s4_val[NI_V_RZ] <= full[M_XZ_FY];
    s4_val[NI_R_TZ] <= 98'(s3_wfx) <<< 16;
    s4_val[NI_R_RX] <= full[M_WY_FX];
    s4_val[NI_R_RY] <= full[M_SR_FX];
  end

  // stage 5: sign and magnitude; zero depth gives zero numerators over one
  always_ff @(posedge clk) begin
    if (rst) begin
      push.vld <= 1'b0;
    end else begin
      push.vld <= s4_vld;
    end
    push.job.den <= s4_zero ? DW'(1) : s4_den;
    for (int i = 0; i < NUM_COUNT; i++) begin
      if (s4_zero) begin
        push.job.num[i].neg <= 1'b0;
        push.job.num[i].mag <= '0;
      end else begin
        push.job.num[i].neg <= s4_val[i][97] ^ NUM_FLIP[i];
        push.job.num[i].mag <= s4_val[i][97] ? MW'(-s4_val[i]) : s4_val[i][MW-1:0];
      end
    end
  end

endmodule

>>> rtl/core/pj_queue.sv
// Small job queue between the front end and the divider back end.
module pj_queue import pj_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  job_req_t push,
  input  logic     pop,
  output job_req_t head
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          store [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign head.vld = (count != '0);
  assign head.job = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.vld) begin
      store[wr_ptr] <= push.job;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.vld) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push.vld) - CW'(pop);
    end
  end

endmodule

>>> rtl/core/pj_back.sv
// Back end: row sequencer, six pipelined restoring dividers, rounding and output register.
module pj_back import pj_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 stereo_mode,
  input  job_req_t             head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           row_index,
  output logic                 last_row,
  output logic signed [OW-1:0] entry [LANES],
  output logic                 saturated
);

  localparam int STEPS = OW;
  localparam logic [OW:0] POS_LIM = {2'b00, {(OW-1){1'b1}}};
  localparam logic [OW:0] NEG_LIM = {2'b01, {(OW-1){1'b0}}};

  logic adv, issue, is_last;
  logic [1:0] row_sel;

  assign adv     = !out_valid || out_ready;
  assign issue   = adv && head.vld;
  assign is_last = (row_sel == (stereo_mode ? ROW_RIGHT_U : ROW_V));
  assign pop     = issue && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_sel <= ROW_LEFT_U;
    end else if (issue) begin
      row_sel <= is_last ? ROW_LEFT_U : row_sel + 2'd1;
    end
  end

  num_t zero_num;
  num_t sel [LANES];
  assign zero_num = '0;

  always_comb begin
    case (row_sel)
      ROW_V: begin
        sel[LANE_TX] = zero_num;
        sel[LANE_TY] = head.job.num[NI_V_TY];
        sel[LANE_TZ] = head.job.num[NI_V_TZ];
        sel[LANE_RX] = head.job.num[NI_V_RX];
        sel[LANE_RY] = head.job.num[NI_V_RY];
        sel[LANE_RZ] = head.job.num[NI_V_RZ];
      end
      ROW_RIGHT_U: begin
        sel[LANE_TX] = head.job.num[NI_U_TX];
        sel[LANE_TY] = zero_num;
        sel[LANE_TZ] = head.job.num[NI_R_TZ];
        sel[LANE_RX] = head.job.num[NI_R_RX];
        sel[LANE_RY] = head.job.num[NI_R_RY];
        sel[LANE_RZ] = head.job.num[NI_U_RZ];
      end
      default: begin
        sel[LANE_TX] = head.job.num[NI_U_TX];
        sel[LANE_TY] = zero_num;
        sel[LANE_TZ] = head.job.num[NI_U_TZ];
        sel[LANE_RX] = head.job.num[NI_U_RX];
        sel[LANE_RY] = head.job.num[NI_U_RY];
        sel[LANE_RZ] = head.job.num[NI_U_RZ];
      end
    endcase
  end

  // issue stage
  logic          i_vld, i_last;
  logic [1:0]    i_row;
  logic [DW-1:0] i_den;
  num_t          i_num [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      i_vld <= 1'b0;
    end else if (adv) begin
      i_vld <= issue;
    end
    if (adv) begin
      i_row  <= row_sel;
      i_last <= is_last;
      i_den  <= head.job.den;
      i_num  <= sel;
    end
  end

  // divider pipeline; qb holds remaining numerator bits on top, quotient bits below
  logic          vld_s [STEPS+1];
  logic          lst_s [STEPS+1];
  logic [1:0]    row_s [STEPS+1];
  logic [DW-1:0] den_s [STEPS+1];
  logic [DW-2:0] rem_s [LANES][STEPS+1];
  logic [OW-1:0] qb_s  [LANES][STEPS+1];
  logic          ovf_s [LANES][STEPS+1];
  logic          neg_s [LANES][STEPS+1];

  // overflow check: quotient reaches 2^48 when the top bits already reach or exceed Z*Z
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s[0] <= 1'b0;
    end else if (adv) begin
      vld_s[0] <= i_vld;
    end
    if (adv) begin
      lst_s[0] <= i_last;
      row_s[0] <= i_row;
      den_s[0] <= i_den;
      for (int l = 0; l < LANES; l++) begin
        ovf_s[l][0] <= DW'(i_num[l].mag[MW-1:OW]) >= i_den;
        rem_s[l][0] <= (DW-1)'(i_num[l].mag[MW-1:OW]);
        qb_s[l][0]  <= i_num[l].mag[OW-1:0];
        neg_s[l][0] <= i_num[l].neg;
      end
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k+1] <= 1'b0;
      end else if (adv) begin
        vld_s[k+1] <= vld_s[k];
      end
      if (adv) begin
        lst_s[k+1] <= lst_s[k];
        row_s[k+1] <= row_s[k];
        den_s[k+1] <= den_s[k];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DW-1:0] trial;
      logic          ge;
      assign trial = {rem_s[l][k], qb_s[l][k][OW-1]};
      assign ge    = (trial >= den_s[k]);

      always_ff @(posedge clk) begin
        if (adv) begin
          rem_s[l][k+1] <= (DW-1)'(ge ? trial - den_s[k] : trial);
          qb_s[l][k+1]  <= {qb_s[l][k][OW-2:0], ge};
          ovf_s[l][k+1] <= ovf_s[l][k];
          neg_s[l][k+1] <= neg_s[l][k];
        end
      end
    end
  end

  // rounding stage: half away from zero on the magnitude
  logic          r_vld, r_last;
  logic [1:0]    r_row;
  logic [OW:0]   r_q   [LANES];
  logic          r_ovf [LANES];
  logic          r_neg [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      r_vld <= 1'b0;
    end else if (adv) begin
      r_vld <= vld_s[STEPS];
    end
    if (adv) begin
      r_last <= lst_s[STEPS];
      r_row  <= row_s[STEPS];
      for (int l = 0; l < LANES; l++) begin
        r_q[l]   <= {1'b0, qb_s[l][STEPS]}
                  + (OW+1)'({rem_s[l][STEPS], 1'b0} >= den_s[STEPS]);
        r_ovf[l] <= ovf_s[l][STEPS];
        r_neg[l] <= neg_s[l][STEPS];
      end
    end
  end

  logic [OW:0]          lim  [LANES];
  logic                 sat  [LANES];
  logic [OW-1:0]        mag  [LANES];
  logic signed [OW-1:0] fin  [LANES];
  logic                 any_sat;

  always_comb begin
    any_sat = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      lim[l] = r_neg[l] ? NEG_LIM : POS_LIM;
      sat[l] = r_ovf[l] || (r_q[l] > lim[l]);
      mag[l] = sat[l] ? lim[l][OW-1:0] : r_q[l][OW-1:0];
      fin[l] = r_neg[l] ? -$signed(mag[l]) : $signed(mag[l]);
      any_sat = any_sat | sat[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= r_vld;
    end
    if (adv) begin
      row_index <= r_row;
      last_row  <= r_last;
      entry     <= fin;
      saturated <= any_sat;
    end
  end

endmodule
